[hdl/ima_pkg.sv]
// ----------------------------------------------------------------------------
// ima_pkg
// shared types and constants of the interval moving average block
// ----------------------------------------------------------------------------
package ima_pkg;

  localparam int WINDOW_LEN = 10;
  localparam int INTERVAL_W = 20;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W      = INTERVAL_W + COUNT_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int CFG_AW     = 3;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = INTERVAL_W'(1000);
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST = INTERVAL_W'(15 * 60 * 1000);

  // register select, taken from the word address bit
  localparam logic REG_MIN_INTERVAL = 1'b0;
  localparam logic REG_MAX_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    CMD_MARK   = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2
  } ima_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLAMP,
    ST_WINDOW,
    ST_DIV_GO,
    ST_DIVIDE,
    ST_DONE
  } ima_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ima_div_status_t;

endpackage

[hdl/interval_moving_average.sv]
// ----------------------------------------------------------------------------
// interval_moving_average
// windowed moving average of the intervals between timestamped events
// ----------------------------------------------------------------------------
// usage
//   input stream: in_tuser carries the command (mark, record, clear), in_tdata
//   the 32-bit millisecond timestamp. every input transfer yields exactly one
//   output transfer with the current average, the window fill and a flag in
//   out_tuser that is set when a record event added a sample.
//   apb port: min_interval_ms at 0x0, max_interval_ms at 0x4, 20 bits each;
//   write only while no event is in flight.
// sequencing
//   mark, clear, unused codes and records without a mark or a later time:
//   execute, done, output register; records past the maximum add a clamp step;
//   accepted records add clamp, window, div_go and divide steps, the bit-serial
//   divider giving one quotient bit per cycle over the 24-bit window sum. one
//   event is in work at a time; in_tready is high only in idle, so the next
//   input transfer can follow in the cycle after the result is loaded.
// reset
//   synchronous, active low: no mark, empty window, average zero, registers
//   back to 1000 and 900000.
// stall
//   a finished result waits in the output register; the sequencer holds its
//   last step until out_tready frees that register.
// ----------------------------------------------------------------------------
module interval_moving_average (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] now_ms
  input  logic [1:0]                      in_tuser,   // [1:0] command
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [19:0] average_ms, [23:20] sample_count
  output logic                            out_tuser,  // [0] accepted
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ima_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IW = ima_pkg::INTERVAL_W;
  localparam int TW = ima_pkg::TIME_W;

  // configuration registers
  logic [IW-1:0]                   min_r;
  logic [IW-1:0]                   max_r;
  logic                            cfg_wr;

  // sequencer
  ima_pkg::ima_state_t             state_r, state_nxt;
  ima_pkg::ima_cmd_t               cmd_r;
  logic [TW-1:0]                   now_r;
  logic [TW-1:0]                   diff_r, diff_nxt;
  logic [TW:0]                     diff_full;
  logic [TW-1:0]                   clamped;
  logic [IW-1:0]                   elapsed_r, elapsed_nxt;
  logic                            took_r, took_nxt;

  // window state
  logic [TW-1:0]                   mark_r, mark_nxt;
  logic [IW-1:0]                   ring_mem [ima_pkg::WINDOW_LEN];
  logic [IW-1:0]                   oldest_r;
  logic [ima_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [ima_pkg::COUNT_W-1:0]     fill_r, fill_nxt;
  logic [ima_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [IW-1:0]                   mean_r, mean_nxt;
  logic                            window_full;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [IW-1:0]                   out_avg_r;
  logic [3:0]                      out_cnt_r;
  logic                            out_acc_r;
  logic                            out_load;

  // divider
  logic                            div_start;
  ima_pkg::ima_div_status_t        div_status;
  logic [ima_pkg::SUM_W-1:0]       div_quo;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == ima_pkg::REG_MAX_INTERVAL) ? 32'(max_r) : 32'(min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= ima_pkg::MIN_INTERVAL_RST;
      max_r <= ima_pkg::MAX_INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ima_pkg::REG_MIN_INTERVAL: min_r <= cfg_pwdata[IW-1:0];
        ima_pkg::REG_MAX_INTERVAL: max_r <= cfg_pwdata[IW-1:0];
        default:                   min_r <= min_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  // borrow in the top bit means the clock lies before the mark
  assign diff_full   = {1'b0, now_r} - {1'b0, mark_r};
  // short intervals are raised to the minimum
  assign clamped     = (diff_r < TW'(min_r)) ? TW'(min_r) : diff_r;
  assign window_full = (fill_r == ima_pkg::COUNT_W'(ima_pkg::WINDOW_LEN));

  assign in_tready = (state_r == ima_pkg::ST_IDLE);
  assign out_load  = (state_r == ima_pkg::ST_DONE) && (!out_valid_r || out_tready);
  assign div_start = (state_r == ima_pkg::ST_DIV_GO);

  always_comb begin
    state_nxt   = state_r;
    diff_nxt    = diff_r;
    elapsed_nxt = elapsed_r;
    took_nxt    = took_r;
    mark_nxt    = mark_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    mean_nxt    = mean_r;
    unique case (state_r)
      ima_pkg::ST_IDLE: begin
        took_nxt = 1'b0;
        if (in_tvalid) begin
          state_nxt = ima_pkg::ST_EXEC;
        end
      end
      ima_pkg::ST_EXEC: begin
        state_nxt = ima_pkg::ST_DONE;
        case (cmd_r)
          ima_pkg::CMD_MARK: begin
            mark_nxt = now_r;
          end
          ima_pkg::CMD_RECORD: begin
            diff_nxt = diff_full[TW-1:0];
            // needs a mark and time strictly past it
            if (mark_r != '0 && !diff_full[TW] && diff_full[TW-1:0] != '0) begin
              state_nxt = ima_pkg::ST_CLAMP;
            end
          end
          ima_pkg::CMD_CLEAR: begin
            mark_nxt = '0;
            head_nxt = '0;
            fill_nxt = '0;
            sum_nxt  = '0;
            mean_nxt = '0;
          end
          default: begin
            state_nxt = ima_pkg::ST_DONE;
          end
        endcase
      end
      ima_pkg::ST_CLAMP: begin
        mark_nxt    = now_r;
        elapsed_nxt = clamped[IW-1:0];
        // idle time beyond the maximum only moves the mark
        if (clamped > TW'(max_r)) begin
          state_nxt = ima_pkg::ST_DONE;
        end else begin
          state_nxt = ima_pkg::ST_WINDOW;
        end
      end
      ima_pkg::ST_WINDOW: begin
        took_nxt = 1'b1;
        if (window_full) begin
          sum_nxt = sum_r - ima_pkg::SUM_W'(oldest_r) + ima_pkg::SUM_W'(elapsed_r);
        end else begin
          sum_nxt  = sum_r + ima_pkg::SUM_W'(elapsed_r);
          fill_nxt = fill_r + 1'b1;
        end
        if (head_r == ima_pkg::IDX_W'(ima_pkg::WINDOW_LEN - 1)) begin
          head_nxt = '0;
        end else begin
          head_nxt = head_r + 1'b1;
        end
        state_nxt = ima_pkg::ST_DIV_GO;
      end
      ima_pkg::ST_DIV_GO: begin
        state_nxt = ima_pkg::ST_DIVIDE;
      end
      ima_pkg::ST_DIVIDE: begin
        if (div_status.done) begin
          mean_nxt  = div_quo[IW-1:0];
          state_nxt = ima_pkg::ST_DONE;
        end
      end
      ima_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = ima_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ima_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ima_pkg::ST_IDLE;
      took_r      <= 1'b0;
      mark_r      <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      took_r      <= took_nxt;
      mark_r      <= mark_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
    diff_r    <= diff_nxt;
    elapsed_r <= elapsed_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r <= ima_pkg::ima_cmd_t'(in_tuser);
      now_r <= in_tdata;
    end
    if (out_load) begin
      out_avg_r <= mean_r;
      out_cnt_r <= 4'(fill_r);
      out_acc_r <= took_r;
    end
  end

  // ring of the last intervals; the slot at the head is the oldest once full
  always_ff @(posedge clk) begin
    oldest_r <= ring_mem[head_r];
    if (state_r == ima_pkg::ST_WINDOW) begin
      ring_mem[head_r] <= elapsed_r;
    end
  end

  // ---------------------------------------------------------------- divider
  ima_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .status   (div_status),
    .quotient (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_avg_r};
  assign out_tuser  = out_acc_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ima_pkg::COUNT_W'(ima_pkg::WINDOW_LEN))
    else $error("window fill beyond window length");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < ima_pkg::IDX_W'(ima_pkg::WINDOW_LEN))
    else $error("ring head out of range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> fill_r != '0)
    else $error("divider started with an empty window");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> state_r == ima_pkg::ST_DIVIDE)
    else $error("divider finished outside the divide step");

  a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && took_r |-> fill_r != '0)
    else $error("accepted sample with empty window");
`endif

endmodule

[hdl/ima_divider.sv]
// ----------------------------------------------------------------------------
// ima_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ima_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ima_pkg::SUM_W-1:0]       dividend,
  input  logic [ima_pkg::COUNT_W-1:0]     divisor,
  output ima_pkg::ima_div_status_t        status,
  output logic [ima_pkg::SUM_W-1:0]       quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [ima_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ima_pkg::SUM_W-1:0]         quo_r, quo_nxt;
  logic [ima_pkg::COUNT_W-1:0]       rem_r, rem_nxt;
  logic [ima_pkg::COUNT_W-1:0]       div_r, div_nxt;
  logic [ima_pkg::COUNT_W:0]         rem_shift;
  logic [ima_pkg::COUNT_W+1:0]       trial;

  // shift in next dividend bit and try a subtract
  assign rem_shift = {rem_r, quo_r[ima_pkg::SUM_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ima_pkg::DIV_CNT_W'(ima_pkg::SUM_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial[ima_pkg::COUNT_W+1]) begin
        rem_nxt = rem_shift[ima_pkg::COUNT_W-1:0];
        quo_nxt = {quo_r[ima_pkg::SUM_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[ima_pkg::COUNT_W-1:0];
        quo_nxt = {quo_r[ima_pkg::SUM_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule
